// ===== rtl/core/ale_pkg.sv =====
// ale_pkg: shared widths, request kinds and the result record of the array list engine.
// No dependencies; every other file of the block refers to it by scoped name.
`default_nettype none

package ale_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int KIND_W  = 3;
   localparam int POS_W   = 7;
   localparam int VAL_W   = 32;
   localparam int FOUND_W = 6;
   localparam int LEN_W   = 7;
   localparam int CAP_W   = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND = 3'd0,
      KIND_INSERT = 3'd1,
      KIND_DELETE = 3'd2,
      KIND_SET    = 3'd3,
      KIND_GET    = 3'd4,
      KIND_SEARCH = 3'd5,
      KIND_CLEAR  = 3'd6
   } kind_type;

   typedef struct packed {
      logic                      ok;
      logic signed [VAL_W-1:0]   read_value;
      logic [FOUND_W-1:0]        found_position;
      logic [LEN_W-1:0]          length;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/ale_req_if.sv =====
// ale_req_if: request channel of the array list engine (valid/ready plus request fields).
// Depends on ale_pkg for field widths.
`default_nettype none

interface ale_req_if;
   logic                             valid;
   logic                             ready;
   logic [ale_pkg::KIND_W-1:0]       kind;
   logic [ale_pkg::POS_W-1:0]        position;
   logic signed [ale_pkg::VAL_W-1:0] value;

   modport source (output valid, kind, position, value, input ready);
   modport sink   (input valid, kind, position, value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ale_rsp_if.sv =====
// ale_rsp_if: response channel of the array list engine (valid/ready plus result fields).
// Depends on ale_pkg for field widths.
`default_nettype none

interface ale_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             ok;
   logic signed [ale_pkg::VAL_W-1:0] read_value;
   logic [ale_pkg::FOUND_W-1:0]      found_position;
   logic [ale_pkg::LEN_W-1:0]        length;

   modport source (output valid, ok, read_value, found_position, length, input ready);
   modport sink   (input valid, ok, read_value, found_position, length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ale_ram.sv =====
// ale_ram: generic single-clock RAM, one write port and one registered read port.
// Depends on ale_pkg for parameter defaults only.
`default_nettype none

module ale_ram #(
   parameter int WIDTH = ale_pkg::VAL_W,
   parameter int DEPTH = ale_pkg::DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ale_seq.sv =====
// ale_seq: request sequencer of the array list engine; walks the entry RAM one read per cycle
// while no finished result waits unclaimed, and owns the element count and the response
// register. Depends on ale_pkg, ale_req_if, ale_rsp_if and ale_ram.
`default_nettype none

module ale_seq #(
   parameter int DEPTH = ale_pkg::DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [ale_pkg::LEN_W-1:0]  limit,
   ale_req_if.sink                         req,
   ale_rsp_if.source                       rsp
);

   localparam int AW = $clog2(DEPTH);

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_INSERT,
      OP_DELETE,
      OP_SET,
      OP_GET,
      OP_SEARCH,
      OP_CLEAR
   } op_type;

   state_type                       state_ff, state_in;
   op_type                          op_ff, op_in;
   logic [ale_pkg::LEN_W-1:0]       count_ff, count_in;
   logic [ale_pkg::POS_W-1:0]       idx_ff, idx_in;
   logic [ale_pkg::POS_W-1:0]       rem_ff, rem_in;
   logic [ale_pkg::POS_W-1:0]       at_ff, at_in;
   logic [ale_pkg::VAL_W-1:0]       val_ff, val_in;
   logic                            pend_ff, pend_in;
   logic [ale_pkg::POS_W-1:0]       pidx_ff, pidx_in;
   logic                            res_valid_ff, res_valid_in;
   ale_pkg::result_type             res_ff, res_in;

   logic                            rd_en;
   logic [AW-1:0]                   rd_addr;
   logic [ale_pkg::VAL_W-1:0]       rd_data;
   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic [ale_pkg::VAL_W-1:0]       wr_data;
   logic                            slot_free;
   ale_pkg::kind_type               kind;

   ale_ram #(
      .WIDTH (ale_pkg::VAL_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free = !res_valid_ff || rsp.ready;
   assign kind      = ale_pkg::kind_type'(req.kind);

   always_comb begin
      logic [ale_pkg::POS_W-1:0] at_sel;
      logic                      fin;

      state_in     = state_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      at_in        = at_ff;
      val_in       = val_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      res_valid_in = res_valid_ff;
      res_in       = res_ff;
      rd_en        = 1'b0;
      rd_addr      = AW'(idx_ff);
      wr_en        = 1'b0;
      wr_addr      = AW'(at_ff);
      wr_data      = val_ff;
      at_sel       = count_ff;
      fin          = 1'b0;

      if (rsp.ready) begin
         res_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_WALK;
               val_in   = req.value;
               pend_in  = 1'b0;
               op_in    = OP_NONE;
               rem_in   = '0;
               idx_in   = '0;
               at_in    = req.position;
               unique case (kind)
                  ale_pkg::KIND_APPEND, ale_pkg::KIND_INSERT: begin
                     if (count_ff < limit) begin
                        if (kind == ale_pkg::KIND_INSERT && req.position < count_ff) begin
                           at_sel = req.position;
                        end
                        op_in  = OP_INSERT;
                        at_in  = at_sel;
                        // shift walks down from the top entry to the insert point
                        idx_in = count_ff - 7'd1;
                        rem_in = count_ff - at_sel;
                     end
                  end
                  ale_pkg::KIND_DELETE: begin
                     if (req.position < count_ff) begin
                        op_in  = OP_DELETE;
                        idx_in = req.position + 7'd1;
                        rem_in = count_ff - req.position - 7'd1;
                     end
                  end
                  ale_pkg::KIND_SET: begin
                     if (req.position < count_ff) begin
                        op_in = OP_SET;
                     end
                  end
                  ale_pkg::KIND_GET: begin
                     if (req.position < count_ff) begin
                        op_in  = OP_GET;
                        idx_in = req.position;
                        rem_in = 7'd1;
                     end
                  end
                  ale_pkg::KIND_SEARCH: begin
                     op_in  = OP_SEARCH;
                     idx_in = '0;
                     rem_in = count_ff;
                  end
                  ale_pkg::KIND_CLEAR: begin
                     op_in = OP_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_WALK: begin
            // whole step holds while a finished result is still unclaimed
            if (slot_free) begin
               res_in = '0;

               // read stage
               if (rem_ff != '0) begin
                  rd_en   = 1'b1;
                  pend_in = 1'b1;
                  pidx_in = idx_ff;
                  rem_in  = rem_ff - 7'd1;
                  idx_in  = (op_ff == OP_INSERT) ? idx_ff - 7'd1 : idx_ff + 7'd1;
               end else begin
                  pend_in = 1'b0;
               end

               // write-back stage; it trails the read by two entries, no overlap
               if (pend_ff) begin
                  if (op_ff == OP_INSERT) begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(pidx_ff + 7'd1);
                     wr_data = rd_data;
                  end else if (op_ff == OP_DELETE) begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(pidx_ff - 7'd1);
                     wr_data = rd_data;
                  end
               end

               priority if (pend_ff && op_ff == OP_GET) begin
                  fin               = 1'b1;
                  res_in.ok         = 1'b1;
                  res_in.read_value = rd_data;
               end else if (pend_ff && op_ff == OP_SEARCH && rd_data == val_ff) begin
                  fin                   = 1'b1;
                  res_in.ok             = 1'b1;
                  res_in.found_position = pidx_ff[ale_pkg::FOUND_W-1:0];
               end else if (rem_ff == '0 && !pend_ff) begin
                  fin = 1'b1;
                  unique case (op_ff)
                     OP_INSERT: begin
                        wr_en     = 1'b1;
                        wr_addr   = AW'(at_ff);
                        wr_data   = val_ff;
                        count_in  = count_ff + 7'd1;
                        res_in.ok = 1'b1;
                     end
                     OP_DELETE: begin
                        count_in  = count_ff - 7'd1;
                        res_in.ok = 1'b1;
                     end
                     OP_SET: begin
                        wr_en     = 1'b1;
                        wr_addr   = AW'(at_ff);
                        wr_data   = val_ff;
                        res_in.ok = 1'b1;
                     end
                     OP_CLEAR: begin
                        count_in  = '0;
                        res_in.ok = 1'b1;
                     end
                     default: begin
                     end
                  endcase
               end else begin
               end

               if (fin) begin
                  state_in      = ST_IDLE;
                  res_valid_in  = 1'b1;
                  res_in.length = count_in;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_NONE;
         count_ff     <= '0;
         rem_ff       <= '0;
         pend_ff      <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         res_valid_ff <= res_valid_in;
      end
      idx_ff  <= idx_in;
      at_ff   <= at_in;
      val_ff  <= val_in;
      pidx_ff <= pidx_in;
      res_ff  <= res_in;
   end

   assign req.ready          = (state_ff == ST_IDLE);
   assign rsp.valid          = res_valid_ff;
   assign rsp.ok             = res_ff.ok;
   assign rsp.read_value     = res_ff.read_value;
   assign rsp.found_position = res_ff.found_position;
   assign rsp.length         = res_ff.length;

endmodule

`default_nettype wire

// ===== rtl/core/array_list_engine_unit.sv =====
// array_list_engine_unit: top level of the array list engine (capacity register, sequencer).
// Depends on ale_pkg, ale_req_if, ale_rsp_if, ale_seq and ale_ram.
//
// Ordered list of up to DEPTH signed 32-bit words kept in one single-port-read RAM. Each
// request item (append, insert, delete, set, get, search, clear) produces exactly one
// response item with ok, read_value, found_position and the new length. One item is in
// work at a time. The shift and scan walks read one entry per cycle while no response
// waits unclaimed, and write each entry back from the registered read port. A new request
// is taken as soon as the sequencer is idle, even while the previous response still waits
// in the output register. The walk then holds at every step until that response is taken.
// The capacity CSR (reset 64) is written through csr_wr_en/csr_wr_data; the limit in force
// is the smaller of it and DEPTH. No clearing pass is needed after reset: entries above
// the length are never read.
`default_nettype none

module array_list_engine_unit #(
   parameter int DEPTH = ale_pkg::DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   ale_req_if.sink                         req_chan,
   ale_rsp_if.source                       rsp_chan,
   input  wire logic                       csr_wr_en,
   input  wire logic [ale_pkg::CAP_W-1:0]  csr_wr_data
);

   // capacity CSR, write-only
   logic [ale_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic [ale_pkg::LEN_W-1:0] limit;

   always_comb begin
      cap_in = csr_wr_en ? csr_wr_data : cap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= ale_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // effective limit: min(capacity, DEPTH); DEPTH term only taken when it fits
   assign limit = (32'(cap_ff) < DEPTH) ? cap_ff : ale_pkg::LEN_W'(DEPTH);

   ale_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .limit (limit),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   // one item in flight: an accepted request always drops ready on the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request ready stayed high after accept");

   // the list never grows beyond the RAM
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> 32'(rsp_chan.length) <= DEPTH)
      else $error("reported length exceeds DEPTH");

   // a failed request reports no data and no position
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ok |->
         rsp_chan.read_value == '0 && rsp_chan.found_position == '0)
      else $error("failed response carries data");

endmodule

`default_nettype wire

// ===== tb/array_list_engine_unit_tb.sv =====
// array_list_engine_unit_tb: self-checking bench for the array list engine; a directed table
// followed by random request phases under varied capacity, idling and back-pressure.
// Depends on ale_pkg, ale_req_if, ale_rsp_if and array_list_engine_unit.

module array_list_engine_unit_tb;
   import ale_pkg::*;

   localparam int LIST_DEPTH = DEPTH_DEFAULT;
   // kind code 7 is not a request; the engine must answer it with ok low
   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
   localparam int NUM_PHASES = 8;
   localparam int HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   ale_req_if req_chan ();
   ale_rsp_if rsp_chan ();

   array_list_engine_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // List predictor: own copy of the entries, the length and the capacity register
   // ---------------------------------------------------------------------------------------
   logic signed [VAL_W-1:0] list_words [LIST_DEPTH];
   int                      list_len;
   logic [CAP_W-1:0]        cap_reg;

   // Results still owed by the engine, oldest first
   result_type awaited_results [$];

   // A directed row may pin the result it expects; it travels alongside the item
   bit         row_pinned;
   result_type row_result;

   int error_count = 0;
   int rsp_count = 0;

   // Idling knobs, percent per cycle; each bump of hold_asked starts a long receiver
   // hold-off, counted down by the receiver in hold_left
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_asked = 0;
   int hold_seen = 0;
   int hold_left = 0;

   // Random mix per kind, in kind order: append, insert, delete, set, get, search,
   // clear, unused
   int grow_mix [8]   = '{35, 20, 5, 10, 14, 15, 0, 1};
   int shrink_mix [8] = '{8, 8, 34, 10, 14, 20, 3, 3};
   int phase_cap [NUM_PHASES]   = '{64, 8, 127, 1, 63, 0, 32, 64};
   int phase_items [NUM_PHASES] = '{300, 250, 300, 150, 300, 80, 250, 270};

   typedef struct {
      bit                      is_cap;
      logic [CAP_W-1:0]        cap;
      logic [KIND_W-1:0]       kind;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
      bit                      pinned;
      result_type              fixed;
   } plan_row_type;

   plan_row_type plan [$];

   // Apply one request to the predicted list and return the result it must produce
   function automatic result_type list_apply(input logic [KIND_W-1:0] k,
                                             input logic [POS_W-1:0] p,
                                             input logic signed [VAL_W-1:0] v);
      result_type r;
      int lim;
      int at;
      int i;
      r = '0;
      lim = (int'(cap_reg) < LIST_DEPTH) ? int'(cap_reg) : LIST_DEPTH;
      case (k)
         KIND_APPEND, KIND_INSERT: begin
            // full list: nothing moves; insert past the end lands at the end
            if (list_len < lim) begin
               at = (k == KIND_INSERT && int'(p) < list_len) ? int'(p) : list_len;
               for (i = list_len; i > at; i--)
                  list_words[i] = list_words[i-1];
               list_words[at] = v;
               list_len++;
               r.ok = 1'b1;
            end
         end
         KIND_DELETE: begin
            if (int'(p) < list_len) begin
               for (i = int'(p); i + 1 < list_len; i++)
                  list_words[i] = list_words[i+1];
               list_len--;
               r.ok = 1'b1;
            end
         end
         KIND_SET: begin
            if (int'(p) < list_len) begin
               list_words[p] = v;
               r.ok = 1'b1;
            end
         end
         KIND_GET: begin
            if (int'(p) < list_len) begin
               r.read_value = list_words[p];
               r.ok = 1'b1;
            end
         end
         KIND_SEARCH: begin
            for (i = 0; i < list_len && !r.ok; i++) begin
               if (list_words[i] == v) begin
                  r.ok = 1'b1;
                  r.found_position = i[FOUND_W-1:0];
               end
            end
         end
         KIND_CLEAR: begin
            list_len = 0;
            r.ok = 1'b1;
         end
         default: ;
      endcase
      r.length = list_len[LEN_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      if (error_count <= 40)
         $display("ERROR response %0d: %s got %0d expected %0d", rsp_count, what, got, want);
   endtask

   // ---------------------------------------------------------------------------------------
   // Monitor: everything sampled at the rising edge, inputs change only at the falling one.
   // Accepted items feed the predictor, accepted results are checked against the oldest
   // expectation.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      result_type pred;
      if (reset) begin
         list_len = 0;
         cap_reg = CAP_RESET;
         awaited_results.delete();
      end else begin
         if (csr_wr_en)
            cap_reg = csr_wr_data;
         if (req_chan.valid && req_chan.ready) begin
            pred = list_apply(req_chan.kind, req_chan.position, req_chan.value);
            awaited_results.push_back(row_pinned ? row_result : pred);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_count++;
            if (awaited_results.size() == 0) begin
               report_mismatch("result with no item pending, length", rsp_chan.length, 0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_chan.ok !== want.ok)
                  report_mismatch("ok", rsp_chan.ok, want.ok);
               if (rsp_chan.read_value !== want.read_value)
                  report_mismatch("read_value", rsp_chan.read_value, want.read_value);
               if (rsp_chan.found_position !== want.found_position)
                  report_mismatch("found_position", rsp_chan.found_position,
                                  want.found_position);
               if (rsp_chan.length !== want.length)
                  report_mismatch("length", rsp_chan.length, want.length);
            end
         end
      end
   end

   // Receiver: random stalls, plus a counted hold-off that lets the engine back up
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready = ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sender side; every task is entered and left just after a falling edge
   // ---------------------------------------------------------------------------------------
   task automatic offer_item(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                             input logic signed [VAL_W-1:0] v, input bit pinned,
                             input result_type fixed);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.kind = k;
      req_chan.position = p;
      req_chan.value = v;
      row_pinned = pinned;
      row_result = fixed;
      do
         @(posedge clock);
      while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Stop offering until every owed result has come back
   task automatic settle_list();
      req_chan.valid = 1'b0;
      while (awaited_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] c);
      csr_wr_en = 1'b1;
      csr_wr_data = c;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic add_row(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                          input logic signed [VAL_W-1:0] v, input bit pinned,
                          input logic ok, input logic signed [VAL_W-1:0] rd,
                          input logic [FOUND_W-1:0] fp, input logic [LEN_W-1:0] len);
      plan_row_type row;
      row = '{is_cap: 1'b0, cap: '0, kind: k, position: p, value: v, pinned: pinned,
              fixed: '{ok: ok, read_value: rd, found_position: fp, length: len}};
      plan.push_back(row);
   endtask

   task automatic add_cap(input logic [CAP_W-1:0] c);
      plan_row_type row;
      row = '{is_cap: 1'b1, cap: c, kind: '0, position: '0, value: '0, pinned: 1'b0,
              fixed: '0};
      plan.push_back(row);
   endtask

   // Generous ceiling: the slow run ends far below this timeout
   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int ph;
      int n;
      int j;
      int roll;
      int acc;
      int lim;
      bit growing;
      logic [KIND_W-1:0] k;
      logic [POS_W-1:0] p;
      logic signed [VAL_W-1:0] v;

      // every input known from time zero
      req_chan.valid = 1'b0;
      req_chan.kind = KIND_APPEND;
      req_chan.position = '0;
      req_chan.value = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      row_pinned = 1'b0;
      row_result = '0;
      phase_cap[6] = $urandom_range(2, 62);

      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed table. Pinned rows: empty list after reset, extremes, failures.
      add_row(KIND_GET,    7'd0,   32'sd0,        1'b1, 1'b0, 32'sd0, 6'd0, 7'd0);
      add_row(KIND_DELETE, 7'd0,   32'sd0,        1'b1, 1'b0, 32'sd0, 6'd0, 7'd0);
      add_row(KIND_SET,    7'd0,   32'sd5,        1'b1, 1'b0, 32'sd0, 6'd0, 7'd0);
      add_row(KIND_SEARCH, 7'd0,   32'sd0,        1'b1, 1'b0, 32'sd0, 6'd0, 7'd0);
      add_row(KIND_UNUSED, 7'd127, -32'sd1,       1'b1, 1'b0, 32'sd0, 6'd0, 7'd0);
      add_row(KIND_APPEND, 7'd0,   32'sh7FFFFFFF, 1'b1, 1'b1, 32'sd0, 6'd0, 7'd1);
      add_row(KIND_APPEND, 7'd0,   32'sh80000000, 1'b1, 1'b1, 32'sd0, 6'd0, 7'd2);
      add_row(KIND_GET,    7'd0,   32'sd0,        1'b1, 1'b1, 32'sh7FFFFFFF, 6'd0, 7'd2);
      add_row(KIND_GET,    7'd1,   32'sd0,        1'b1, 1'b1, 32'sh80000000, 6'd0, 7'd2);
      add_row(KIND_INSERT, 7'd0,   -32'sd1,       1'b1, 1'b1, 32'sd0, 6'd0, 7'd3);
      // position far past the end turns into an append
      add_row(KIND_INSERT, 7'd127, 32'sh55555555, 1'b1, 1'b1, 32'sd0, 6'd0, 7'd4);
      add_row(KIND_INSERT, 7'd1,   32'shAAAAAAAA, 1'b0, 1'b0, 32'sd0, 6'd0, 7'd0);
      add_row(KIND_SEARCH, 7'd0,   32'sh80000000, 1'b0, 1'b0, 32'sd0, 6'd0, 7'd0);
      add_row(KIND_SET,    7'd2,   32'sd0,        1'b0, 1'b0, 32'sd0, 6'd0, 7'd0);
      add_row(KIND_SET,    7'd5,   32'sd1,        1'b1, 1'b0, 32'sd0, 6'd0, 7'd5);
      add_row(KIND_DELETE, 7'd0,   32'sd0,        1'b0, 1'b0, 32'sd0, 6'd0, 7'd0);
      add_row(KIND_DELETE, 7'd3,   32'sd0,        1'b0, 1'b0, 32'sd0, 6'd0, 7'd0);
      add_row(KIND_GET,    7'd64,  32'sd0,        1'b1, 1'b0, 32'sd0, 6'd0, 7'd3);
      add_row(KIND_SEARCH, 7'd0,   32'sh12345678, 1'b1, 1'b0, 32'sd0, 6'd0, 7'd3);
      add_row(KIND_CLEAR,  7'd0,   32'sd0,        1'b1, 1'b1, 32'sd0, 6'd0, 7'd0);
      add_row(KIND_APPEND, 7'd0,   32'sd0,        1'b1, 1'b1, 32'sd0, 6'd0, 7'd1);
      // capacity 1 with one entry: the list is full
      add_cap(7'd1);
      add_row(KIND_APPEND, 7'd0,   32'sd1,        1'b1, 1'b0, 32'sd0, 6'd0, 7'd1);
      add_row(KIND_INSERT, 7'd0,   32'sd1,        1'b1, 1'b0, 32'sd0, 6'd0, 7'd1);
      // capacity dropped below the length: entry stays readable, growth refused
      add_cap(7'd0);
      add_row(KIND_GET,    7'd0,   32'sd0,        1'b1, 1'b1, 32'sd0, 6'd0, 7'd1);
      add_row(KIND_APPEND, 7'd0,   32'sd2,        1'b1, 1'b0, 32'sd0, 6'd0, 7'd1);

      foreach (plan[i]) begin
         if (plan[i].is_cap) begin
            settle_list();
            write_capacity(plan[i].cap);
         end else begin
            offer_item(plan[i].kind, plan[i].position, plan[i].value, plan[i].pinned,
                       plan[i].fixed);
         end
      end

      // Random phases: the list is steered to grow to its limit and then shrink,
      // so full lists, long shifts and deep searches all come up.
      growing = 1'b1;
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         settle_list();
         write_capacity(phase_cap[ph][CAP_W-1:0]);
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 58;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 58;
            end
            default: begin
               send_idle_pct = 27;
               recv_stall_pct = 27;
            end
         endcase
         for (n = 0; n < phase_items[ph]; n++) begin
            // long receiver hold-off while items keep coming: the engine backs up
            if (ph == 2 && n == 30)
               hold_asked++;
            // sender waits for the engine to empty out mid-phase
            if (ph == 4 && n == 120)
               settle_list();

            lim = (int'(cap_reg) < LIST_DEPTH) ? int'(cap_reg) : LIST_DEPTH;
            if (list_len == 0)
               growing = 1'b1;
            else if (list_len >= lim && $urandom_range(0, 3) == 0)
               growing = 1'b0;

            roll = $urandom_range(0, 99);
            acc = 0;
            k = KIND_UNUSED;
            for (j = 7; j >= 0; j--) begin
               acc += growing ? grow_mix[7-j] : shrink_mix[7-j];
               if (roll < acc && k == KIND_UNUSED && j != 0)
                  k = KIND_W'(7 - j);
            end

            if ($urandom_range(0, 4) == 0)
               p = POS_W'($urandom_range(0, 127));
            else
               p = POS_W'($urandom_range(0, list_len));

            if (k == KIND_SEARCH && list_len > 0 && $urandom_range(0, 4) < 3) begin
               v = list_words[$urandom_range(0, list_len - 1)];
            end else begin
               roll = $urandom_range(0, 9);
               if (roll == 0) begin
                  case ($urandom_range(0, 3))
                     0: v = 32'sh7FFFFFFF;
                     1: v = 32'sh80000000;
                     2: v = 32'sd0;
                     default: v = -32'sd1;
                  endcase
               end else if (roll < 5) begin
                  // small values repeat, so searches meet duplicates
                  v = $urandom_range(0, 15);
                  v = v - 32'sd8;
               end else begin
                  v = $urandom;
               end
            end
            offer_item(k, p, v, 1'b0, '0);
         end
      end

      settle_list();
      repeat (LIST_DEPTH + 4) @(negedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
